// File: rtl/button_press_classifier_unit_defines.svh
// assertion macros shared by the button press classifier rtl
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BPC_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BPC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/bpc_pkg.sv
// shared types and constants of the button press classifier
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam int BUTTONS_DEF = 5;
    localparam int OUT_FIELDS  = 5;
    localparam int PRESS_BITS  = 5;

    localparam int CNT_W   = 8;
    localparam int STATE_W = 3;
    localparam int CFG_IDX_W = 2;

    typedef logic [STATE_W-1:0] bpc_state_t;

    localparam bpc_state_t ST_NEUTRAL    = 3'd0;
    localparam bpc_state_t ST_DEBOUNCE   = 3'd1;
    localparam bpc_state_t ST_SHORT_DOWN = 3'd2;
    localparam bpc_state_t ST_LONG_DOWN  = 3'd3;
    localparam bpc_state_t ST_SHORT_UP   = 3'd4;
    localparam bpc_state_t ST_LONG_UP    = 3'd5;
    localparam bpc_state_t ST_SHORT_REDB = 3'd6;
    localparam bpc_state_t ST_LONG_REDB  = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_COUNT = 2'd1;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = 8'd5;
    localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 8'd50;
    localparam logic [CNT_W-1:0] COUNTDOWN_RESET  = 8'h05;
    localparam logic [CNT_W-1:0] HOLD_MAX         = 8'hFF;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] long_press_count;
    } bpc_cfg_t;

    typedef struct packed {
        logic fire;
        logic poll;
        logic clear;
        logic tick;
        logic down;
    } bpc_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/bpc_button.sv
// one button: step countdown, hold counter and press state machine
`timescale 1ns / 1ps
`default_nettype none
`include "button_press_classifier_unit_defines.svh"

module bpc_button (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bpc_pkg::bpc_cfg_t   cfg,
    input  wire bpc_pkg::bpc_ctrl_t  ctrl,
    output bpc_pkg::bpc_state_t      state_next
);

    bpc_pkg::bpc_state_t            state_reg;
    logic [bpc_pkg::CNT_W-1:0]      hold_reg;
    logic [bpc_pkg::CNT_W-1:0]      hold_next;
    logic [bpc_pkg::CNT_W-1:0]      cnt_reg;
    logic [bpc_pkg::CNT_W-1:0]      cnt_next;
    logic [bpc_pkg::CNT_W-1:0]      cnt_dec;
    logic [bpc_pkg::CNT_W-1:0]      hold_inc;
    bpc_pkg::bpc_state_t            adv_state;
    logic [bpc_pkg::CNT_W-1:0]      adv_hold;

    always_comb
    begin
        cnt_dec = cnt_reg;
        if (ctrl.tick && (cnt_reg != '0))
        begin
            cnt_dec = cnt_reg - bpc_pkg::CNT_W'(1);
        end
        hold_inc = (hold_reg == bpc_pkg::HOLD_MAX) ? bpc_pkg::HOLD_MAX
                                                   : hold_reg + bpc_pkg::CNT_W'(1);
    end

    // one step of the press machine
    always_comb
    begin
        adv_state = state_reg;
        adv_hold  = hold_reg;
        case (state_reg)
            bpc_pkg::ST_NEUTRAL:
            begin
                if (ctrl.down)
                begin
                    adv_hold  = '0;
                    adv_state = bpc_pkg::ST_DEBOUNCE;
                end
            end
            bpc_pkg::ST_DEBOUNCE:
            begin
                adv_state = ctrl.down ? bpc_pkg::ST_SHORT_DOWN : bpc_pkg::ST_NEUTRAL;
                adv_hold  = hold_inc;
            end
            bpc_pkg::ST_SHORT_DOWN:
            begin
                if (ctrl.down)
                begin
                    adv_hold = hold_inc;
                    if (hold_inc > cfg.long_press_count)
                    begin
                        adv_state = bpc_pkg::ST_LONG_DOWN;
                    end
                end
                else
                begin
                    adv_state = bpc_pkg::ST_SHORT_UP;
                end
            end
            bpc_pkg::ST_LONG_DOWN:
            begin
                if (!ctrl.down)
                begin
                    adv_state = bpc_pkg::ST_LONG_UP;
                end
            end
            bpc_pkg::ST_SHORT_UP:
            begin
                if (ctrl.down)
                begin
                    adv_state = bpc_pkg::ST_SHORT_REDB;
                    adv_hold  = '0;
                end
            end
            bpc_pkg::ST_LONG_UP:
            begin
                if (ctrl.down)
                begin
                    adv_state = bpc_pkg::ST_LONG_REDB;
                    adv_hold  = '0;
                end
            end
            bpc_pkg::ST_SHORT_REDB:
            begin
                if (ctrl.down)
                begin
                    adv_hold  = hold_inc;
                    adv_state = bpc_pkg::ST_SHORT_DOWN;
                end
                else
                begin
                    adv_state = bpc_pkg::ST_SHORT_UP;
                end
            end
            bpc_pkg::ST_LONG_REDB:
            begin
                if (ctrl.down)
                begin
                    adv_hold  = hold_inc;
                    adv_state = bpc_pkg::ST_SHORT_DOWN;
                end
                else
                begin
                    adv_state = bpc_pkg::ST_LONG_UP;
                end
            end
            default:
            begin
                adv_state = state_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        hold_next  = hold_reg;
        cnt_next   = cnt_reg;
        if (ctrl.fire)
        begin
            if (ctrl.clear)
            begin
                state_next = bpc_pkg::ST_NEUTRAL;
            end
            else if (ctrl.poll)
            begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    state_next = adv_state;
                    hold_next  = adv_hold;
                    cnt_next   = cfg.debounce_ticks;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpc_pkg::ST_NEUTRAL;
            hold_reg  <= '0;
            cnt_reg   <= bpc_pkg::COUNTDOWN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
            cnt_reg   <= cnt_next;
        end
    end

    `BPC_ASSERT_NEXT(a_hold_sat, hold_reg == bpc_pkg::HOLD_MAX,
        (hold_reg == bpc_pkg::HOLD_MAX) || (hold_reg == '0), "hold counter wrapped")
    `BPC_ASSERT_NEXT(a_clear_neutral, ctrl.fire && ctrl.clear,
        state_reg == bpc_pkg::ST_NEUTRAL, "clear did not reach neutral")
    `BPC_ASSERT_NEXT(a_idle_hold, !ctrl.fire,
        $stable(state_reg) && $stable(hold_reg) && $stable(cnt_reg), "state moved without a beat")

endmodule

`default_nettype wire

// File: rtl/button_press_classifier_unit.sv
// top level of the button press classifier: input stage, button cells, result stage
`timescale 1ns / 1ps
`default_nettype none
`include "button_press_classifier_unit_defines.svh"

// an accepted beat shows its result at out_valid once it moves from the input register into the result register
// throughput: one beat per cycle while out_stall is low, input register and result register run back to back
// the per-button update is one level of logic between the input and result registers
// reset: all buttons neutral, hold counters zero, countdowns five, both stages empty
// reset also sets debounce_ticks to 5 and long_press_count to 50

module button_press_classifier_unit #(
    parameter int BUTTONS = bpc_pkg::BUTTONS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              cmd,
    input  wire logic [3:0]                        raw_port_c,
    input  wire logic [7:0]                        raw_port_b,
    input  wire logic                              tick,
    input  wire logic [2:0]                        button_index,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bpc_pkg::STATE_W-1:0]            state_button0,
    output logic [bpc_pkg::STATE_W-1:0]            state_button1,
    output logic [bpc_pkg::STATE_W-1:0]            state_button2,
    output logic [bpc_pkg::STATE_W-1:0]            state_button3,
    output logic [bpc_pkg::STATE_W-1:0]            state_button4,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bpc_pkg::CNT_W-1:0]         cfg_data
);

    // configuration registers, always ready
    bpc_pkg::bpc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= bpc_pkg::DEBOUNCE_RESET;
            cfg_reg.long_press_count <= bpc_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpc_pkg::CFG_DEBOUNCE_TICKS:   cfg_reg.debounce_ticks   <= cfg_data;
                bpc_pkg::CFG_LONG_PRESS_COUNT: cfg_reg.long_press_count <= cfg_data;
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input stage
    logic       in_valid_reg;
    logic       in_valid_next;
    logic       cmd_reg;
    logic [3:0] port_c_reg;
    logic [7:0] port_b_reg;
    logic       tick_reg;
    logic [2:0] index_reg;

    // the held beat moves into the result stage when that stage frees up
    logic advance;
    logic in_accept;

    assign advance   = in_valid_reg && (!out_valid || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg    <= cmd;
            port_c_reg <= raw_port_c;
            port_b_reg <= raw_port_b;
            tick_reg   <= tick;
            index_reg  <= button_index;
        end
    end

    // active-low ports folded into one pressed vector, button 4 on port b bit 1
    logic [bpc_pkg::PRESS_BITS-1:0] pressed;

    assign pressed = ~{port_b_reg[1], port_c_reg};

    // button cells
    bpc_pkg::bpc_state_t cell_next [BUTTONS];

    for (genvar b = 0; b < BUTTONS; b++)
    begin : g_btn
        bpc_pkg::bpc_ctrl_t ctrl;
        logic               down;

        // buttons past the wired ports always read as released
        if (b < bpc_pkg::PRESS_BITS)
        begin : g_wired
            assign down = pressed[b];
        end
        else
        begin : g_open
            assign down = 1'b0;
        end

        assign ctrl.fire  = advance;
        assign ctrl.poll  = !cmd_reg;
        assign ctrl.clear = cmd_reg && (index_reg == 3'(b));
        assign ctrl.tick  = tick_reg;
        assign ctrl.down  = down;

        bpc_button u_button (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg        (cfg_reg),
            .ctrl       (ctrl),
            .state_next (cell_next[b])
        );
    end

    // result stage
    logic                out_valid_reg;
    logic                out_valid_next;
    bpc_pkg::bpc_state_t out_state_reg [bpc_pkg::OUT_FIELDS];

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    for (genvar f = 0; f < bpc_pkg::OUT_FIELDS; f++)
    begin : g_out
        if (f < BUTTONS)
        begin : g_used
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    out_state_reg[f] <= cell_next[f];
                end
            end
        end
        else
        begin : g_unused
            // no button behind this field, reads as neutral
            always_ff @(posedge clk)
            begin
                out_state_reg[f] <= bpc_pkg::ST_NEUTRAL;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign state_button0 = out_state_reg[0];
    assign state_button1 = out_state_reg[1];
    assign state_button2 = out_state_reg[2];
    assign state_button3 = out_state_reg[3];
    assign state_button4 = out_state_reg[4];

    `BPC_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg, "advanced beat not in result stage")
    `BPC_ASSERT_NOW(a_stall_needs_beat, in_stall, in_valid_reg, "stall without a held beat")
    `BPC_ASSERT_NOW(a_free_no_stall, in_valid_reg && !out_valid_reg, !in_stall,
        "stall while result stage empty")

endmodule

`default_nettype wire
